FILE: design/rwsp_pkg.sv
// shared types and constants for the riff/wave stream parser
// no dependencies
package rwsp_pkg;

    localparam int LengthWidthDefault = 32;
    localparam int QueueDepth = 4;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_RIFF  = 4'd1;
    localparam logic [3:0] ST_SIZE      = 4'd2;
    localparam logic [3:0] ST_BAD_WAVE  = 4'd3;
    localparam logic [3:0] ST_UNKNOWN   = 4'd4;
    localparam logic [3:0] ST_CAPACITY  = 4'd5;
    localparam logic [3:0] ST_TOO_BIG   = 4'd6;
    localparam logic [3:0] ST_FORMAT    = 4'd7;
    localparam logic [3:0] ST_24BIT     = 4'd8;

    localparam logic [1:0] CFG_STREAM_LENGTH = 2'd0;
    localparam logic [1:0] CFG_CAPACITY      = 2'd1;
    localparam logic [1:0] CFG_STRICT        = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666d7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    typedef logic [31:0] skip_tags_t [20];
    localparam skip_tags_t SKIP_TAGS = '{
        32'h4a554e4b, 32'h62657874, 32'h4c475756, 32'h52657355, 32'h49443320,
        32'h69643320, 32'h534d4544, 32'h69584d4c, 32'h4c495354, 32'h5f504d58,
        32'h464c4c52, 32'h736d706c, 32'h73706c70, 32'h73707267, 32'h7370636c,
        32'h73706363, 32'h7372746e, 32'h73706361, 32'h61636964, 32'h696e7374
    };

    // classification handed from front to back
    // a byte may carry a sample, a final status, or both (sample first)
    typedef struct packed {
        logic        is_sample;
        logic        is_final;
        logic [15:0] sample;
        logic [3:0]  code;
    } rwsp_op_t;

    typedef enum logic [6:0] {
        PH_HEAD = 7'b0000001,
        PH_CHDR = 7'b0000010,
        PH_SKIP = 7'b0000100,
        PH_FMT  = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_PAD  = 7'b0100000,
        PH_DONE = 7'b1000000
    } phase_t;

    function automatic logic is_skip_tag(input logic [31:0] tag);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 20; i++) begin
            if (tag == SKIP_TAGS[i]) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

FILE: design/riff_wav_stream_parser.sv
// top level of the riff/wave stream parser
// depends on rwsp_pkg, rwsp_front, rwsp_back
//
// Usage: bytes of a RIFF/WAVE file enter on s_axis_* one per transfer. Results
// leave on m_axis_*: tuser 0 is a 16-bit sample, tuser 1 the final status with
// the sample total. After the final status input is taken and dropped until
// reset. Registers are written on cfg_* (0 stream length, 1 capacity, 2 strict).
// Throughput: one byte per cycle while the queue has room; the front part does
// the whole per-byte step combinationally. Each result is written into the
// four-entry queue between front and back and offered from there. The byte that
// closes the last data chunk gives a sample and the final status, which leave
// as two transfers from one queue entry, sample first. When the receiver
// stalls the queue fills and s_axis_tready falls once it is full. Synchronous
// active-low reset returns the parser to the file header, empties the queue
// and restores the registers (stream length 0, capacity 0, strict mode on).
module riff_wav_stream_parser #(
    parameter int LENGTH_WIDTH = rwsp_pkg::LengthWidthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // file_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // sample_value, status_code, sample_total
    output logic [7:0]  m_axis_tuser,   // item_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rwsp_pkg::*;

    logic [31:0] stream_length_reg;
    logic [30:0] capacity_reg;
    logic        strict_reg;
    logic        op_valid, op_ready;
    rwsp_op_t    op;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_length_reg <= '0; capacity_reg <= '0; strict_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STREAM_LENGTH: stream_length_reg <= cfg_data;
                CFG_CAPACITY:      capacity_reg <= cfg_data[30:0];
                CFG_STRICT:        strict_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    rwsp_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
        .stream_length(stream_length_reg), .capacity_samples(capacity_reg),
        .strict_format(strict_reg),
        .op_valid(op_valid), .op_ready(op_ready), .op(op)
    );

    rwsp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .op_valid(op_valid), .op_ready(op_ready), .op(op),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_kind_byte(m_axis_tuser), .out_data(m_axis_tdata)
    );

    // a sample carries no status and no total
    a_sample_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0] == 1'b0) |-> m_axis_tdata[50:16] == '0)
        else $error("sample result carries status bits");
    // a result is only produced from an accepted byte
    a_push_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        op_valid |-> (s_axis_tvalid && s_axis_tready))
        else $error("result without input transfer");
    // status codes stay in range
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[19:16] <= ST_24BIT)
        else $error("status code out of range");
endmodule

FILE: design/rwsp_front.sv
// front part: walks the byte stream, tracks chunks, classifies each byte
// depends on rwsp_pkg
module rwsp_front #(
    parameter int LENGTH_WIDTH = rwsp_pkg::LengthWidthDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic [31:0]       stream_length,
    input  logic [30:0]       capacity_samples,
    input  logic              strict_format,
    output logic              op_valid,
    input  logic              op_ready,
    output rwsp_pkg::rwsp_op_t op
);
    import rwsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] riff_reg, riff_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] clen_reg, clen_next;
    logic [31:0] left_reg, left_next;
    logic [63:0] f0_reg, f0_next, f1_reg, f1_next;
    logic [7:0]  low_reg, low_next;
    logic [30:0] count_reg, count_next;
    logic [31:0] lmask;
    logic        fire;
    logic [31:0] pos;
    logic [32:0] room2;
    logic [15:0] bits;

    assign lmask = 32'(({33'd0, 32'hffffffff}) >> (32 - LENGTH_WIDTH));
    assign in_ready = op_ready;
    assign fire = in_valid && in_ready;
    assign pos = clen_reg - left_reg;
    assign room2 = (capacity_samples > count_reg) ?
                   {1'b0, 32'(capacity_samples - count_reg) << 1} : 33'd0;
    assign bits = f1_reg[63:48];

    // per-byte parse step
    always_comb begin
        logic [31:0] off1, ln;
        logic        fin, bnd, endb, endfmt, startb, startfmt;
        logic [3:0]  code;
        phase_t      sph;
        off1 = offset_reg + ((offset_reg != 32'hffffffff) ? 32'd1 : 32'd0);
        phase_next = phase_reg; offset_next = offset_reg; riff_next = riff_reg;
        tag_next = tag_reg; clen_next = clen_reg; left_next = left_reg;
        f0_next = f0_reg; f1_next = f1_reg; low_next = low_reg;
        count_next = count_reg;
        op_valid = 1'b0;
        op = '0;
        fin = 1'b0; code = ST_OK; bnd = 1'b0; endb = 1'b0; endfmt = 1'b0;
        startb = 1'b0; startfmt = 1'b0; sph = PH_SKIP; ln = clen_reg;
        if (fire && phase_reg != PH_DONE) begin
            offset_next = off1;
            case (phase_reg)
                PH_HEAD: begin
                    tag_next = {tag_reg[23:0], in_byte};
                    if (offset_reg >= 32'd4 && offset_reg <= 32'd7)
                        riff_next = riff_reg | (32'(in_byte) << (8 * offset_reg[1:0]));
                    if (offset_reg == 32'd3 && tag_next != TAG_RIFF) begin
                        fin = 1'b1; code = ST_BAD_RIFF;
                    end else if (offset_reg == 32'd7) begin
                        riff_next = riff_next & lmask;
                        if ({1'b0, riff_next} + 33'd8 != {1'b0, stream_length}) begin
                            fin = 1'b1; code = ST_SIZE;
                        end
                    end else if (offset_reg == 32'd11) begin
                        if (tag_next != TAG_WAVE) begin
                            fin = 1'b1; code = ST_BAD_WAVE;
                        end else bnd = 1'b1;
                    end
                end
                PH_CHDR: begin
                    if (left_reg < 32'd4) tag_next = {tag_reg[23:0], in_byte};
                    else clen_next = clen_reg |
                        (32'(in_byte) << (8 * left_reg[1:0]));
                    left_next = left_reg + 32'd1;
                    if (left_next >= 32'd8) begin
                        ln = clen_next & lmask;
                        clen_next = ln;
                        if (is_skip_tag(tag_reg)) begin
                            startb = 1'b1; sph = PH_SKIP;
                        end else if (tag_reg == TAG_FMT) begin
                            f0_next = '0; f1_next = '0;
                            startb = 1'b1; sph = PH_FMT;
                        end else if (tag_reg == TAG_DATA) begin
                            if ({1'b0, ln} > room2) begin
                                fin = 1'b1; code = ST_CAPACITY;
                            end else if (ln > riff_reg) begin
                                fin = 1'b1; code = ST_TOO_BIG;
                            end else if (bits == 16'd24) begin
                                fin = 1'b1; code = ST_24BIT;
                            end else begin
                                startb = 1'b1;
                                sph = (bits == 16'd16) ? PH_DATA : PH_SKIP;
                            end
                        end else begin
                            fin = 1'b1; code = ST_UNKNOWN;
                        end
                    end
                end
                PH_SKIP: begin
                    left_next = left_reg - 32'd1;
                    endb = (left_next == 32'd0);
                end
                PH_FMT: begin
                    if (pos < 32'd16) begin
                        if (pos[3]) f1_next = f1_reg | (64'(in_byte) << (8 * pos[2:0]));
                        else        f0_next = f0_reg | (64'(in_byte) << (8 * pos[2:0]));
                    end
                    left_next = left_reg - 32'd1;
                    endb = (left_next == 32'd0);
                    endfmt = endb;
                end
                PH_DATA: begin
                    if (!pos[0]) low_next = in_byte;
                    else begin
                        op_valid = 1'b1;
                        op.is_sample = 1'b1;
                        op.sample = {in_byte, low_reg};
                        if (count_reg != 31'h7fffffff) count_next = count_reg + 31'd1;
                    end
                    left_next = left_reg - 32'd1;
                    endb = (left_next == 32'd0);
                end
                PH_PAD: bnd = 1'b1;
                default: phase_next = PH_DONE;
            endcase
            // chunk body start, possibly empty
            if (startb) begin
                left_next = ln;
                if (ln == 32'd0) begin
                    endb = 1'b1; endfmt = (sph == PH_FMT);
                end else phase_next = sph;
            end
            if (endb) begin
                if (endfmt && strict_format && (f0_next[15:0] != 16'd1 ||
                    f0_next[31:16] != 16'd2 || f0_next[63:32] != 32'd44100 ||
                    f1_next[31:0] != 32'd176400 || f1_next[47:32] != 16'd4 ||
                    f1_next[63:48] != 16'd16)) begin
                    fin = 1'b1; code = ST_FORMAT;
                end else if (clen_next[0]) phase_next = PH_PAD;
                else bnd = 1'b1;
            end
            if (bnd) begin
                if ({1'b0, riff_next} > {1'b0, off1} + 33'd10) begin
                    phase_next = PH_CHDR; left_next = '0; clen_next = '0;
                end else begin
                    fin = 1'b1; code = ST_OK;
                end
            end
            // final status, kept beside a sample from the same byte
            if (fin) begin
                phase_next = PH_DONE;
                op_valid = 1'b1;
                op.is_final = 1'b1;
                op.code = code;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEAD; offset_reg <= '0; riff_reg <= '0; tag_reg <= '0;
            clen_reg <= '0; left_reg <= '0; f0_reg <= '0; f1_reg <= '0;
            low_reg <= '0; count_reg <= '0;
        end else begin
            phase_reg <= phase_next; offset_reg <= offset_next; riff_reg <= riff_next;
            tag_reg <= tag_next; clen_reg <= clen_next; left_reg <= left_next;
            f0_reg <= f0_next; f1_reg <= f1_next; low_reg <= low_next;
            count_reg <= count_next;
        end
    end
endmodule

FILE: design/rwsp_back.sv
// back part: short queue of classified items and output formatting
// depends on rwsp_pkg
module rwsp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_valid,
    output logic               op_ready,
    input  rwsp_pkg::rwsp_op_t op,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_kind_byte,
    output logic [55:0]        out_data
);
    import rwsp_pkg::*;

    localparam int AW = $clog2(QueueDepth);

    rwsp_op_t      mem_reg [QueueDepth];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [30:0]   total_reg, total_next;
    logic          split_reg, split_next;
    logic          push, pop, out_fire, out_is_sample, last_part;
    rwsp_op_t      head;

    assign op_ready = (cnt_reg < (AW+1)'(QueueDepth));
    assign push = op_valid && op_ready;
    assign out_valid = (cnt_reg != '0);
    assign head = mem_reg[rp_reg];
    // an entry with both a sample and a status leaves in two transfers
    assign out_is_sample = head.is_sample && !split_reg;
    assign last_part = !(head.is_sample && head.is_final) || split_reg;
    assign out_fire = out_valid && out_ready;
    assign pop = out_fire && last_part;

    // queue pointers and running sample total
    always_comb begin
        wp_next = push ? wp_reg + 1'b1 : wp_reg;
        rp_next = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        split_next = out_fire ? !last_part : split_reg;
        total_next = total_reg;
        if (out_fire && out_is_sample && total_reg != 31'h7fffffff)
            total_next = total_reg + 31'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; total_reg <= '0;
            split_reg <= 1'b0;
        end else begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
            total_reg <= total_next; split_reg <= split_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= op;
    end

    // output fields
    assign out_kind_byte = {7'd0, ~out_is_sample};
    assign out_data = out_is_sample ? {5'd0, 31'd0, 4'd0, head.sample}
                                    : {5'd0, total_reg, head.code, 16'd0};
endmodule
